// ----- rtl/dspe_pkg.sv -----
// dspe_pkg: shared types, constants and keyword tables of the DOCTYPE path extractor.
// Used by every RTL file of the block; depends on nothing.
`default_nettype none

package dspe_pkg;

	localparam int MAX_PATH    = 512;
	localparam int PREFIX_MAX  = 7;
	localparam int MAX_RESULTS = 8;

	localparam int PLEN_W  = $clog2(MAX_PATH);
	localparam int HOLD_IW = $clog2(PREFIX_MAX + 1);
	localparam int RCNT_W  = $clog2(MAX_RESULTS + 1);
	localparam int PFX_W   = 8 * PREFIX_MAX;
	localparam int CFG_AW  = 2;
	localparam int CFG_DW  = PFX_W;

	localparam logic [PLEN_W-1:0]  PLEN_LAST = PLEN_W'(MAX_PATH - 1);
	localparam logic [HOLD_IW-1:0] HOLD_MAX  = HOLD_IW'(PREFIX_MAX);

	localparam logic [7:0] CH_NEWLINE = 8'h0A;
	localparam logic [7:0] CH_QUOTE   = 8'h22;

	localparam logic [2:0] KW_DOCTYPE_LEN = 3'd7;
	localparam logic [2:0] KW_SYSTEM_LEN  = 3'd6;

	localparam logic [7:0] LINE_LIMIT_RST = 8'd5;

	typedef enum logic [2:0] {
		PH_DOCTYPE,
		PH_SYSTEM,
		PH_QUOTE,
		PH_PATH,
		PH_IDLE
	} phase_t;

	typedef enum logic [2:0] {
		ST_PATH       = 3'd0,
		ST_DONE       = 3'd1,
		ST_NO_DOCTYPE = 3'd2,
		ST_NO_SYSTEM  = 3'd3,
		ST_UNTERM     = 3'd4,
		ST_TOO_LONG   = 3'd5
	} status_t;

	typedef enum logic [CFG_AW-1:0] {
		REG_LINE_LIMIT,
		REG_PREFIX_LEN,
		REG_PREFIX_ONE,
		REG_PREFIX_TWO
	} cfg_reg_t;

	typedef struct packed {
		logic [7:0]                  line_limit;
		logic [2:0]                  prefix_len;
		logic [PREFIX_MAX-1:0] [7:0] prefix_one;
		logic [PREFIX_MAX-1:0] [7:0] prefix_two;
	} cfg_t;

	typedef struct packed {
		logic [7:0] pbyte;
		status_t    status;
	} result_t;

	typedef struct packed {
		logic [RCNT_W-1:0]               cnt;
		result_t [MAX_RESULTS-1:0]       ent;
	} rlist_t;

	function automatic logic [7:0] kw_doctype_char(input logic [2:0] idx);
		logic [7:0] c;
		unique case (idx)
			3'd0: c = 8'h44;
			3'd1: c = 8'h4F;
			3'd2: c = 8'h43;
			3'd3: c = 8'h54;
			3'd4: c = 8'h59;
			3'd5: c = 8'h50;
			3'd6: c = 8'h45;
			default: c = 8'h00;
		endcase
		return c;
	endfunction

	function automatic logic [7:0] kw_system_char(input logic [2:0] idx);
		logic [7:0] c;
		unique case (idx)
			3'd0: c = 8'h53;
			3'd1: c = 8'h59;
			3'd2: c = 8'h53;
			3'd3: c = 8'h54;
			3'd4: c = 8'h45;
			3'd5: c = 8'h4D;
			default: c = 8'h00;
		endcase
		return c;
	endfunction

endpackage

`default_nettype wire

// ----- rtl/dspe_if.sv -----
// dspe_if: handshake interfaces for document bytes, results and register writes.
// Depends on dspe_pkg for widths.
`default_nettype none

interface dspe_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       first_byte;
	logic       end_of_input;

	modport source(output valid, data_byte, first_byte, end_of_input, input ready);
	modport sink(input valid, data_byte, first_byte, end_of_input, output ready);
endinterface

interface dspe_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] path_byte;
	logic [2:0] status;
	logic       last_of_run;

	modport source(output valid, path_byte, status, last_of_run, input ready);
	modport sink(input valid, path_byte, status, last_of_run, output ready);
endinterface

interface dspe_cfg_if;
	logic                        valid;
	logic                        ready;
	logic [dspe_pkg::CFG_AW-1:0] addr;
	logic [dspe_pkg::CFG_DW-1:0] data;

	modport source(output valid, addr, data, input ready);
	modport sink(input valid, addr, data, output ready);
endinterface

`default_nettype wire

// ----- rtl/dspe_cfg.sv -----
// dspe_cfg: configuration register file (line limit, header length, two URI headers).
// Depends on dspe_pkg and dspe_cfg_if.
`default_nettype none

module dspe_cfg (
	input  wire logic         clk,
	input  wire logic         arst_n,
	dspe_cfg_if.sink          cfg,
	output dspe_pkg::cfg_t    regs
);

	dspe_pkg::cfg_t regs_q;

	assign cfg.ready = 1'b1;
	assign regs      = regs_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_q.line_limit <= dspe_pkg::LINE_LIMIT_RST;
			regs_q.prefix_len <= '0;
			regs_q.prefix_one <= '0;
			regs_q.prefix_two <= '0;
		end else if (cfg.valid && cfg.ready) begin
			unique case (dspe_pkg::cfg_reg_t'(cfg.addr))
				dspe_pkg::REG_LINE_LIMIT: regs_q.line_limit <= cfg.data[7:0];
				dspe_pkg::REG_PREFIX_LEN: regs_q.prefix_len <= cfg.data[2:0];
				dspe_pkg::REG_PREFIX_ONE: regs_q.prefix_one <= cfg.data;
				dspe_pkg::REG_PREFIX_TWO: regs_q.prefix_two <= cfg.data;
			endcase
		end
	end

endmodule

`default_nettype wire

// ----- rtl/dspe_core.sv -----
// dspe_core: input register, scan state and the per-byte step that builds one result list.
// Depends on dspe_pkg and dspe_in_if.
`default_nettype none

module dspe_core (
	input  wire logic            clk,
	input  wire logic            arst_n,
	dspe_in_if.sink              doc,
	input  wire dspe_pkg::cfg_t  cfg,
	input  wire logic            free,
	output logic                 load,
	output dspe_pkg::rlist_t     rlist
);

	localparam int PM = dspe_pkg::PREFIX_MAX;
	localparam int MR = dspe_pkg::MAX_RESULTS;
	localparam int PW = dspe_pkg::PLEN_W;
	localparam int IW = dspe_pkg::HOLD_IW;

	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       first_s1;
	logic       last_s1;

	dspe_pkg::phase_t phase_q;
	logic [2:0]       kw_q;
	logic [7:0]       line_q;
	logic [PW-1:0]    plen_q;
	logic [1:0]       psm_q;
	logic [7:0]       hold_q [PM];

	dspe_pkg::phase_t  ph;
	logic [2:0]        kwc;
	logic [7:0]        lc;
	logic [PW-1:0]     pl;
	logic [1:0]        psm;
	logic [1:0]        mm;
	logic [3:0]        kw_r;
	logic [2:0]        plim;
	logic              hold_we;
	logic [IW-1:0]     hold_idx;
	logic [IW-1:0]     flush_n;
	logic              has_byte;
	logic              has_stat;
	dspe_pkg::status_t stat;
	logic [7:0]        hv [MR];

	function automatic logic [3:0] kw_step(input logic [2:0] cnt, input logic [7:0] ch,
			input logic sys);
		logic [2:0] len;
		logic [2:0] c;
		logic [2:0] nc;
		logic [7:0] want;
		logic [7:0] head;
		len  = sys ? dspe_pkg::KW_SYSTEM_LEN : dspe_pkg::KW_DOCTYPE_LEN;
		c    = (cnt >= len) ? 3'd0 : cnt;
		want = sys ? dspe_pkg::kw_system_char(c) : dspe_pkg::kw_doctype_char(c);
		head = sys ? dspe_pkg::kw_system_char(3'd0) : dspe_pkg::kw_doctype_char(3'd0);
		if (ch == want) begin
			nc = c + 3'd1;
		end else begin
			nc = (ch == head) ? 3'd1 : 3'd0;
		end
		if (nc == len) begin
			return {1'b1, 3'd0};
		end
		return {1'b0, nc};
	endfunction

	// held bytes: path length capped at the hold depth
	function automatic logic [IW-1:0] held(input logic [PW-1:0] n);
		return (n > PW'(PM)) ? dspe_pkg::HOLD_MAX : n[IW-1:0];
	endfunction

	assign load      = valid_s1 && free;
	assign doc.ready = !valid_s1 || load;

	always_comb begin : next_state
		ph       = phase_q;
		kwc      = kw_q;
		lc       = line_q;
		pl       = plen_q;
		psm      = psm_q;
		mm       = 2'b00;
		kw_r     = '0;
		hold_we  = 1'b0;
		hold_idx = plen_q[IW-1:0];
		flush_n  = '0;
		has_byte = 1'b0;
		has_stat = 1'b0;
		stat     = dspe_pkg::ST_DONE;
		plim     = (cfg.prefix_len > 3'(PM)) ? 3'(PM) : cfg.prefix_len;

		if (first_s1) begin
			ph  = dspe_pkg::PH_DOCTYPE;
			kwc = '0;
			lc  = '0;
			pl  = '0;
			psm = '0;
		end

		unique case (ph)
			dspe_pkg::PH_DOCTYPE: begin
				if (byte_s1 == dspe_pkg::CH_NEWLINE && lc != 8'hFF) begin
					lc = lc + 8'd1;
				end
				kw_r = kw_step(kwc, byte_s1, 1'b0);
				kwc  = kw_r[2:0];
				if (kw_r[3]) begin
					if (lc > cfg.line_limit) begin
						ph       = dspe_pkg::PH_IDLE;
						has_stat = 1'b1;
						stat     = dspe_pkg::ST_NO_DOCTYPE;
					end else begin
						ph = dspe_pkg::PH_SYSTEM;
					end
				end
			end
			dspe_pkg::PH_SYSTEM: begin
				kw_r = kw_step(kwc, byte_s1, 1'b1);
				kwc  = kw_r[2:0];
				if (kw_r[3]) begin
					ph = dspe_pkg::PH_QUOTE;
				end
			end
			dspe_pkg::PH_QUOTE: begin
				if (byte_s1 == dspe_pkg::CH_QUOTE) begin
					ph  = dspe_pkg::PH_PATH;
					pl  = '0;
					psm = (cfg.prefix_len != 3'd0) ? 2'b11 : 2'b00;
				end
			end
			dspe_pkg::PH_PATH: begin
				if (byte_s1 == dspe_pkg::CH_QUOTE) begin
					if (psm != 2'b00) begin
						flush_n = held(pl);
					end
					psm      = 2'b00;
					ph       = dspe_pkg::PH_IDLE;
					has_stat = 1'b1;
					stat     = dspe_pkg::ST_DONE;
				end else if (pl == dspe_pkg::PLEN_LAST) begin
					if (psm != 2'b00) begin
						flush_n = held(pl);
					end
					psm      = 2'b00;
					ph       = dspe_pkg::PH_IDLE;
					has_stat = 1'b1;
					stat     = dspe_pkg::ST_TOO_LONG;
				end else begin
					// header length lowered under the held count
					if (psm != 2'b00 && pl >= PW'(plim)) begin
						flush_n = held(pl);
						psm     = 2'b00;
					end
					if (psm != 2'b00) begin
						hold_we  = 1'b1;
						hold_idx = pl[IW-1:0];
						mm[0]    = cfg.prefix_one[hold_idx] == byte_s1;
						mm[1]    = cfg.prefix_two[hold_idx] == byte_s1;
						mm       = mm & psm;
						pl       = pl + PW'(1);
						if (mm == 2'b00) begin
							flush_n = held(pl);
							psm     = 2'b00;
						end else if (pl == PW'(plim)) begin
							psm = 2'b00;
						end else begin
							psm = mm;
						end
					end else begin
						pl       = pl + PW'(1);
						has_byte = 1'b1;
					end
				end
			end
			default: begin
				ph = dspe_pkg::PH_IDLE;
			end
		endcase

		if (last_s1) begin
			case (ph)
				dspe_pkg::PH_DOCTYPE: begin
					has_stat = 1'b1;
					stat     = dspe_pkg::ST_NO_DOCTYPE;
				end
				dspe_pkg::PH_SYSTEM, dspe_pkg::PH_QUOTE: begin
					has_stat = 1'b1;
					stat     = dspe_pkg::ST_NO_SYSTEM;
				end
				dspe_pkg::PH_PATH: begin
					if (psm != 2'b00) begin
						flush_n = held(pl);
					end
					has_stat = 1'b1;
					stat     = dspe_pkg::ST_UNTERM;
				end
				default: begin
				end
			endcase
			ph  = dspe_pkg::PH_DOCTYPE;
			kwc = '0;
			lc  = '0;
			pl  = '0;
			psm = '0;
		end
	end

	// result list: held bytes, then a plain path byte, then the status
	always_comb begin : outputs
		for (int i = 0; i < MR; i++) begin
			if (i < PM) begin
				hv[i] = (hold_we && hold_idx == IW'(i)) ? byte_s1 : hold_q[i];
			end else begin
				hv[i] = 8'h00;
			end
		end
		for (int k = 0; k < MR; k++) begin
			if (dspe_pkg::RCNT_W'(k) < dspe_pkg::RCNT_W'(flush_n)) begin
				rlist.ent[k] = '{pbyte: hv[k], status: dspe_pkg::ST_PATH};
			end else if (dspe_pkg::RCNT_W'(k) == dspe_pkg::RCNT_W'(flush_n) && has_byte) begin
				rlist.ent[k] = '{pbyte: byte_s1, status: dspe_pkg::ST_PATH};
			end else begin
				rlist.ent[k] = '{pbyte: 8'h00, status: stat};
			end
		end
		rlist.cnt = dspe_pkg::RCNT_W'(flush_n) + dspe_pkg::RCNT_W'(has_byte)
			+ dspe_pkg::RCNT_W'(has_stat);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			phase_q  <= dspe_pkg::PH_DOCTYPE;
			kw_q     <= '0;
			line_q   <= '0;
			plen_q   <= '0;
			psm_q    <= '0;
		end else begin
			if (doc.valid && doc.ready) begin
				valid_s1 <= 1'b1;
			end else if (load) begin
				valid_s1 <= 1'b0;
			end
			if (load) begin
				phase_q <= ph;
				kw_q    <= kwc;
				line_q  <= lc;
				plen_q  <= pl;
				psm_q   <= psm;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (doc.valid && doc.ready) begin
			byte_s1  <= doc.data_byte;
			first_s1 <= doc.first_byte;
			last_s1  <= doc.end_of_input;
		end
		if (load && hold_we) begin
			hold_q[hold_idx] <= byte_s1;
		end
	end

endmodule

`default_nettype wire

// ----- rtl/dspe_obuf.sv -----
// dspe_obuf: result register for a byte's results, drained one a cycle unless stalled.
// Depends on dspe_pkg and dspe_out_if.
`default_nettype none

module dspe_obuf (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              load,
	input  wire dspe_pkg::rlist_t  rlist,
	output logic                   free,
	dspe_out_if.source             path
);

	localparam int MR = dspe_pkg::MAX_RESULTS;
	localparam int CW = dspe_pkg::RCNT_W;

	logic [CW-1:0]                   cnt_q;
	dspe_pkg::result_t [MR-1:0]      ent_q;
	logic                            fire;

	assign fire             = path.valid && path.ready;
	assign free             = (cnt_q == '0) || (cnt_q == CW'(1) && fire);
	assign path.valid       = cnt_q != '0;
	assign path.path_byte   = ent_q[0].pbyte;
	assign path.status      = ent_q[0].status;
	assign path.last_of_run = cnt_q == CW'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (load) begin
			cnt_q <= rlist.cnt;
		end else if (fire) begin
			cnt_q <= cnt_q - CW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			ent_q <= rlist.ent;
		end else if (fire) begin
			for (int i = 0; i < MR - 1; i++) begin
				ent_q[i] <= ent_q[i + 1];
			end
		end
	end

endmodule

`default_nettype wire

// ----- rtl/doctype_system_path_extractor_unit.sv -----
// doctype_system_path_extractor_unit: top level of the DOCTYPE system-path extractor.
// Depends on dspe_pkg, dspe_if, dspe_cfg, dspe_core and dspe_obuf.
//
//  channel | dir | payload                               | accepted when
//  doc     | in  | data_byte, first_byte, end_of_input   | doc.valid && doc.ready
//  path    | out | path_byte, status, last_of_run        | path.valid && path.ready
//  cfg     | in  | addr (register index), data           | cfg.valid && cfg.ready
//
// One byte per cycle while each byte gives at most one result and path is ready; a byte
// giving several results holds the doc channel while the result register drains.
// Each doc byte is held in the input register, and its results in the result register.
// Reset clears scan state and config registers; no clearing pass. cfg is always ready.
// A stalled path channel stalls doc once the input register is also full.
`default_nettype none

module doctype_system_path_extractor_unit (
	input  wire logic clk,
	input  wire logic arst_n,
	dspe_in_if.sink    doc,
	dspe_out_if.source path,
	dspe_cfg_if.sink   cfg
);

	dspe_pkg::cfg_t   cfg_regs;
	dspe_pkg::rlist_t rlist;
	logic             free;
	logic             load;

	dspe_cfg u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.regs   (cfg_regs)
	);

	dspe_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.doc    (doc),
		.cfg    (cfg_regs),
		.free   (free),
		.load   (load),
		.rlist  (rlist)
	);

	dspe_obuf u_obuf (
		.clk    (clk),
		.arst_n (arst_n),
		.load   (load),
		.rlist  (rlist),
		.free   (free),
		.path   (path)
	);

endmodule

`default_nettype wire

// ----- rtl/dspe_chk.sv -----
// dspe_chk: port-level checks on the result channel of the path extractor, bound to the top.
// Depends on dspe_pkg for status codes.
`default_nettype none

module dspe_chk (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       out_valid,
	input wire logic       out_ready,
	input wire logic [7:0] out_byte,
	input wire logic [2:0] out_status,
	input wire logic       out_last
);

	localparam logic [2:0] ST_PATH     = dspe_pkg::ST_PATH;
	localparam logic [2:0] ST_TOO_LONG = dspe_pkg::ST_TOO_LONG;

	a_valid_holds: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result request withdrawn while stalled");

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_status <= ST_TOO_LONG)
		else $error("status code out of range");

	a_status_no_byte: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_status != ST_PATH |-> out_byte == 8'h00)
		else $error("status result carries a byte");

	a_status_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_status != ST_PATH |-> out_last)
		else $error("status result not last of its run");

endmodule

bind doctype_system_path_extractor_unit dspe_chk u_chk (
	.clk        (clk),
	.arst_n     (arst_n),
	.out_valid  (path.valid),
	.out_ready  (path.ready),
	.out_byte   (path.path_byte),
	.out_status (path.status),
	.out_last   (path.last_of_run)
);

`default_nettype wire
